### rtl/core/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

   localparam int unsigned ID_W    = 16;
   localparam int unsigned USES_W  = 16;
   localparam int unsigned STAMP_W = 32;
   localparam int unsigned LIMIT_W = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam logic [USES_W-1:0]  USES_MAX    = 16'hFFFF;
   localparam logic [USES_W-1:0]  USES_FIRST  = 16'd1;
   localparam logic [STAMP_W-1:0] STAMP_MAX   = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    ident;
      logic [USES_W-1:0]  uses;
      logic [STAMP_W-1:0] inserted_at;
   } entry_type;

   typedef struct packed {
      logic      present;
      logic      slot_valid;
      entry_type entry;
   } read_type;

   typedef struct packed {
      logic match;
      logic lower;
   } rank_type;

endpackage

### rtl/core/lfu_req_if.sv
`timescale 1ns / 1ps

interface lfu_req_if;
   logic                      valid;
   logic                      ready;
   logic [lfu_pkg::ID_W-1:0]  candidate_id;

   modport source (output valid, output candidate_id, input ready);
   modport sink   (input valid, input candidate_id, output ready);
endinterface

### rtl/core/lfu_rsp_if.sv
`timescale 1ns / 1ps

interface lfu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic                        evicted;
   logic [lfu_pkg::ID_W-1:0]    evicted_id;
   logic [lfu_pkg::USES_W-1:0]  count_after;

   modport source (output valid, output hit, output evicted, output evicted_id,
                   output count_after, input ready);
   modport sink   (input valid, input hit, input evicted, input evicted_id,
                   input count_after, output ready);
endinterface

### rtl/core/lfu_csr_if.sv
`timescale 1ns / 1ps

interface lfu_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lfu_pkg::LIMIT_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/lfu_table.sv
`timescale 1ns / 1ps

module lfu_table #(
   parameter int unsigned SLOTS = 16,
   parameter int unsigned IDX_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output lfu_pkg::read_type   rd_data,
   output logic [IDX_W-1:0]    rd_idx,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  lfu_pkg::entry_type  wr_entry
);

   lfu_pkg::entry_type mem [SLOTS];

   logic [SLOTS-1:0]   valid_ff;
   logic               present_ff;
   logic               slot_valid_ff;
   lfu_pkg::entry_type entry_ff;
   logic [IDX_W-1:0]   idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         present_ff    <= 1'b0;
         slot_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         present_ff <= rd_en;
         if (rd_en) begin
            slot_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         entry_ff <= mem[rd_addr];
         idx_ff   <= rd_addr;
      end
   end

   assign rd_data.present    = present_ff;
   assign rd_data.slot_valid = slot_valid_ff;
   assign rd_data.entry      = entry_ff;
   assign rd_idx             = idx_ff;

endmodule

### rtl/core/lfu_rank.sv
`timescale 1ns / 1ps

module lfu_rank (
   input  lfu_pkg::entry_type         cand,
   input  lfu_pkg::entry_type         best,
   input  logic                       best_present,
   input  logic [lfu_pkg::ID_W-1:0]   id,
   output lfu_pkg::rank_type          result
);

   localparam int unsigned KEY_W = lfu_pkg::USES_W + lfu_pkg::STAMP_W + lfu_pkg::ID_W;

   logic [KEY_W-1:0] cand_key;
   logic [KEY_W-1:0] best_key;

   assign cand_key = {cand.uses, cand.inserted_at, cand.ident};
   assign best_key = {best.uses, best.inserted_at, best.ident};

   assign result.match = (cand.ident == id);
   assign result.lower = !best_present || (cand_key < best_key);

endmodule

### rtl/core/lfu_slot_replacement_unit.sv
`timescale 1ns / 1ps

// LFU slot table with oldest-insertion tie break. Each request is looked up
// against all SLOTS slots, one slot per cycle through the registered read port
// of the entry memory, while a single comparator tracks the hit and the
// eviction candidate. After its transfer a request passes the scan state, which
// reads the slots, the drain state, which takes in the last read, and the
// finish state, which writes the table and loads the response register; only
// then is the block idle and ready for the next request. A finished response
// waits in its register while the next request is taken; the update stalls
// only if the previous response has still not been taken by then. Reset
// empties the table at once through per-slot valid bits. slots_in_use may be
// written at any time the block is idle; 0 acts as 1 and values above SLOTS
// act as SLOTS.
module lfu_slot_replacement_unit #(
   parameter int unsigned SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   lfu_req_if.sink          req_if,
   lfu_rsp_if.source        rsp_if,
   lfu_csr_if.sink          csr_if
);

   localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned USED_W = $clog2(SLOTS + 1);
   localparam int unsigned CMP_W  = (USED_W > lfu_pkg::LIMIT_W) ? USED_W : lfu_pkg::LIMIT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   lfu_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]             scan_idx_ff, scan_idx_in;
   logic [lfu_pkg::ID_W-1:0]     id_ff, id_in;
   logic [USED_W-1:0]            used_ff, used_in;
   logic                         hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]             hit_slot_ff, hit_slot_in;
   lfu_pkg::entry_type           hit_entry_ff, hit_entry_in;
   logic                         free_found_ff, free_found_in;
   logic [IDX_W-1:0]             free_slot_ff, free_slot_in;
   logic                         victim_found_ff, victim_found_in;
   logic [IDX_W-1:0]             victim_slot_ff, victim_slot_in;
   lfu_pkg::entry_type           victim_entry_ff, victim_entry_in;
   logic [lfu_pkg::STAMP_W-1:0]  req_num_ff, req_num_in;
   logic [lfu_pkg::LIMIT_W-1:0]  slots_in_use_ff, slots_in_use_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic                         rsp_evicted_ff, rsp_evicted_in;
   logic [lfu_pkg::ID_W-1:0]     rsp_evicted_id_ff, rsp_evicted_id_in;
   logic [lfu_pkg::USES_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                         req_xfer;
   logic                         rsp_free;
   logic                         rd_en;
   logic                         finish;
   lfu_pkg::read_type            rd_data;
   logic [IDX_W-1:0]             rd_idx;
   lfu_pkg::rank_type            rank;
   logic [IDX_W-1:0]             wr_addr;
   lfu_pkg::entry_type           wr_entry;

   logic [CMP_W-1:0]             limit_raw;
   logic [CMP_W-1:0]             limit_eff;
   logic                         use_free;
   logic [lfu_pkg::USES_W-1:0]   hit_uses_next;

   assign req_xfer = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   lfu_table #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (scan_idx_ff),
      .rd_data  (rd_data),
      .rd_idx   (rd_idx),
      .wr_en    (finish),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   lfu_rank u_rank (
      .cand         (rd_data.entry),
      .best         (victim_entry_ff),
      .best_present (victim_found_ff),
      .id           (id_ff),
      .result       (rank)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = lfu_pkg::ST_SCAN;
            end
         end
         lfu_pkg::ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = lfu_pkg::ST_DRAIN;
            end
         end
         lfu_pkg::ST_DRAIN: begin
            state_in = lfu_pkg::ST_FINISH;
         end
         lfu_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      rd_en        = 1'b0;
      finish       = 1'b0;
      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         lfu_pkg::ST_SCAN: begin
            rd_en = 1'b1;
         end
         lfu_pkg::ST_DRAIN: begin
            rd_en = 1'b0;
         end
         lfu_pkg::ST_FINISH: begin
            finish = rsp_free;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign limit_raw = CMP_W'(slots_in_use_ff);

   always_comb begin
      limit_eff = limit_raw;
      if (limit_raw == '0) begin
         limit_eff = CMP_W'(1);
      end else if (limit_raw > CMP_W'(SLOTS)) begin
         limit_eff = CMP_W'(SLOTS);
      end
   end

   assign use_free      = free_found_ff && (CMP_W'(used_ff) < limit_eff);
   assign hit_uses_next = (hit_entry_ff.uses == lfu_pkg::USES_MAX) ? hit_entry_ff.uses
                                                                  : hit_entry_ff.uses + 1'b1;

   always_comb begin
      wr_entry.ident = id_ff;
      if (hit_found_ff) begin
         wr_addr              = hit_slot_ff;
         wr_entry.uses        = hit_uses_next;
         wr_entry.inserted_at = hit_entry_ff.inserted_at;
      end else begin
         wr_addr              = use_free ? free_slot_ff : victim_slot_ff;
         wr_entry.uses        = lfu_pkg::USES_FIRST;
         wr_entry.inserted_at = req_num_ff;
      end
   end

   // scan accumulation
   always_comb begin
      scan_idx_in     = scan_idx_ff;
      id_in           = id_ff;
      used_in         = used_ff;
      hit_found_in    = hit_found_ff;
      hit_slot_in     = hit_slot_ff;
      hit_entry_in    = hit_entry_ff;
      free_found_in   = free_found_ff;
      free_slot_in    = free_slot_ff;
      victim_found_in = victim_found_ff;
      victim_slot_in  = victim_slot_ff;
      victim_entry_in = victim_entry_ff;
      if (req_xfer) begin
         scan_idx_in     = '0;
         id_in           = req_if.candidate_id;
         used_in         = '0;
         hit_found_in    = 1'b0;
         free_found_in   = 1'b0;
         victim_found_in = 1'b0;
      end else begin
         if (rd_en && (scan_idx_ff != LAST_IDX)) begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
         if (rd_data.present) begin
            if (rd_data.slot_valid) begin
               used_in = used_ff + 1'b1;
               if (rank.match) begin
                  hit_found_in = 1'b1;
                  hit_slot_in  = rd_idx;
                  hit_entry_in = rd_data.entry;
               end
               if (rank.lower) begin
                  victim_found_in = 1'b1;
                  victim_slot_in  = rd_idx;
                  victim_entry_in = rd_data.entry;
               end
            end else if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_slot_in  = rd_idx;
            end
         end
      end
   end

   always_comb begin
      req_num_in = req_num_ff;
      if (finish && (req_num_ff != lfu_pkg::STAMP_MAX)) begin
         req_num_in = req_num_ff + 1'b1;
      end
   end

   always_comb begin
      slots_in_use_in = slots_in_use_ff;
      if (csr_if.valid && csr_if.ready) begin
         slots_in_use_in = csr_if.data;
      end
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_hit_in        = rsp_hit_ff;
      rsp_evicted_in    = rsp_evicted_ff;
      rsp_evicted_id_in = rsp_evicted_id_ff;
      rsp_count_in      = rsp_count_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in      = 1'b1;
         rsp_hit_in        = hit_found_ff;
         rsp_evicted_in    = !hit_found_ff && !use_free;
         rsp_evicted_id_in = (!hit_found_ff && !use_free) ? victim_entry_ff.ident : '0;
         rsp_count_in      = hit_found_ff ? hit_uses_next : lfu_pkg::USES_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lfu_pkg::ST_IDLE;
         req_num_ff      <= '0;
         slots_in_use_ff <= lfu_pkg::LIMIT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         req_num_ff      <= req_num_in;
         slots_in_use_ff <= slots_in_use_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff       <= scan_idx_in;
      id_ff             <= id_in;
      used_ff           <= used_in;
      hit_found_ff      <= hit_found_in;
      hit_slot_ff       <= hit_slot_in;
      hit_entry_ff      <= hit_entry_in;
      free_found_ff     <= free_found_in;
      free_slot_ff      <= free_slot_in;
      victim_found_ff   <= victim_found_in;
      victim_slot_ff    <= victim_slot_in;
      victim_entry_ff   <= victim_entry_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_evicted_ff    <= rsp_evicted_in;
      rsp_evicted_id_ff <= rsp_evicted_id_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.hit         = rsp_hit_ff;
   assign rsp_if.evicted     = rsp_evicted_ff;
   assign rsp_if.evicted_id  = rsp_evicted_id_ff;
   assign rsp_if.count_after = rsp_count_ff;

`ifndef SYNTHESIS
   a_xfer_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == lfu_pkg::ST_SCAN))
      else $error("request transfer did not start a scan");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("response reports both hit and eviction");

   a_evict_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_evicted_ff) |-> (rsp_evicted_id_ff == '0))
      else $error("evicted identifier set without eviction");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0))
      else $error("response use count is zero");

   a_req_num_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (req_num_ff >= $past(req_num_ff)))
      else $error("request counter went backwards");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int TABLE_SLOTS   = 16;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;
   localparam int REPORT_LIMIT  = 100;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic                       hit;
      logic                       evicted;
      logic [lfu_pkg::ID_W-1:0]   evicted_id;
      logic [lfu_pkg::USES_W-1:0] count_after;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfu_req_if req_ch ();
   lfu_rsp_if rsp_ch ();
   lfu_csr_if csr_ch ();

   lfu_slot_replacement_unit #(.SLOTS(TABLE_SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   logic                         tbl_valid [TABLE_SLOTS] = '{default: 1'b0};
   logic [lfu_pkg::ID_W-1:0]     tbl_ident [TABLE_SLOTS];
   logic [lfu_pkg::USES_W-1:0]   tbl_uses  [TABLE_SLOTS];
   logic [lfu_pkg::STAMP_W-1:0]  tbl_stamp [TABLE_SLOTS];
   logic [lfu_pkg::STAMP_W-1:0]  request_count = '0;
   logic [lfu_pkg::LIMIT_W-1:0]  slot_limit = lfu_pkg::LIMIT_RESET;

   lookup_result_type pending_lookups [$];

   int errors             = 0;
   int cycles             = 0;
   int requests_sent      = 0;
   int responses_seen     = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   event hold_start;
   logic rsp_hold = 1'b0;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Look up one identifier and update the table copy
   function automatic lookup_result_type predict_lookup(input logic [lfu_pkg::ID_W-1:0] id);
      lookup_result_type res;
      int used;
      int hit_slot;
      int free_slot;
      int victim;
      int target;
      int lim;
      res       = '0;
      used      = 0;
      hit_slot  = -1;
      free_slot = -1;
      victim    = -1;
      lim = (slot_limit == 0) ? 1 :
            ((slot_limit > TABLE_SLOTS) ? TABLE_SLOTS : int'(slot_limit));
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         if (tbl_valid[s]) begin
            used++;
            if (tbl_ident[s] == id)
               hit_slot = s;
            if (victim < 0)
               victim = s;
            else if ((tbl_uses[s] != tbl_uses[victim]) ? (tbl_uses[s] < tbl_uses[victim]) :
                     (tbl_stamp[s] != tbl_stamp[victim]) ? (tbl_stamp[s] < tbl_stamp[victim]) :
                     (tbl_ident[s] < tbl_ident[victim]))
               victim = s;
         end else if (free_slot < 0) begin
            free_slot = s;
         end
      end
      if (hit_slot >= 0) begin
         if (tbl_uses[hit_slot] != lfu_pkg::USES_MAX)
            tbl_uses[hit_slot] = tbl_uses[hit_slot] + 1'b1;
         res.hit         = 1'b1;
         res.count_after = tbl_uses[hit_slot];
      end else begin
         if (used < lim && free_slot >= 0) begin
            target = free_slot;
         end else begin
            target         = victim;
            res.evicted    = 1'b1;
            res.evicted_id = tbl_ident[victim];
         end
         tbl_valid[target] = 1'b1;
         tbl_ident[target] = id;
         tbl_uses[target]  = lfu_pkg::USES_FIRST;
         tbl_stamp[target] = request_count;
         res.count_after   = lfu_pkg::USES_FIRST;
      end
      if (request_count != lfu_pkg::STAMP_MAX)
         request_count = request_count + 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            responses_seen = responses_seen + 1;
            got = {rsp_ch.hit, rsp_ch.evicted, rsp_ch.evicted_id, rsp_ch.count_after};
            if (pending_lookups.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("%0t: expected nothing, got %0b/%0b/%04h/%0d", $time,
                           got.hit, got.evicted, got.evicted_id, got.count_after);
               errors++;
            end else begin
               want = pending_lookups.pop_front();
               if (got !== want) begin
                  if (errors < REPORT_LIMIT)
                     $display("%0t: expected %0b/%0b/%04h/%0d, got %0b/%0b/%04h/%0d",
                              $time, want.hit, want.evicted, want.evicted_id,
                              want.count_after, got.hit, got.evicted, got.evicted_id,
                              got.count_after);
                  errors++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            slot_limit = csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            pending_lookups.push_back(predict_lookup(req_ch.candidate_id));
      end
   end

   // Hold off the receiver for a long stretch
   always begin
      @(hold_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   task automatic send_request(input logic [lfu_pkg::ID_W-1:0] id);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.candidate_id <= id;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (responses_seen < requests_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_limit(input logic [lfu_pkg::LIMIT_W-1:0] value);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_traffic(input logic [lfu_pkg::LIMIT_W-1:0] limit_value, input int items,
                              input int idle_pct, input int stall_pct);
      logic [lfu_pkg::ID_W-1:0] pool [24];
      int pool_len;
      write_slot_limit(limit_value);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      pool_len = ((limit_value == 0) ? 1 : (limit_value > TABLE_SLOTS) ? TABLE_SLOTS :
                  int'(limit_value)) + 1 + $urandom_range(0, 6);
      foreach (pool[i])
         pool[i] = 16'($urandom_range(0, 65535));
      repeat (items) begin
         if ($urandom_range(0, 99) < 85)
            send_request(pool[$urandom_range(0, pool_len - 1)]);
         else
            send_request(16'($urandom_range(0, 65535)));
      end
   endtask

   task automatic test_directed_corners();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_request(16'h0000);
      send_request(16'hFFFF);
      write_slot_limit(5'd3);
      send_request(16'h0000);
      send_request(16'hAAAA);
      send_request(16'h5555);
      send_request(16'h5555);
      send_request(16'hAAAA);
      send_request(16'hFFFF);
      send_request(16'h0000);
      // drop the limit below the current fill
      write_slot_limit(5'd0);
      send_request(16'h1234);
      send_request(16'h1234);
      send_request(16'h8001);
      write_slot_limit(5'd1);
      send_request(16'h8001);
      send_request(16'h4002);
      write_slot_limit(5'd31);
      send_request(16'h7FFE);
      send_request(16'h0001);
      send_request(16'h7FFE);
   endtask

   task automatic test_input_backpressure();
      write_slot_limit(5'd3);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      -> hold_start;
      repeat (14)
         send_request(16'($urandom_range(0, 7)));
   endtask

   task automatic test_random_settings();
      run_traffic(5'd1,  140, 0,  0);
      run_traffic(5'd16, 140, 66, 0);
      run_traffic(5'd0,  140, 0,  66);
      run_traffic(5'd31, 140, 28, 28);
      run_traffic(5'd17, 140, 0,  0);
      run_traffic(5'd4,  140, 66, 0);
      run_traffic(5'd9,  140, 0,  66);
      run_traffic(5'd2,  140, 28, 28);
   endtask

   task automatic test_repeated_hits();
      logic [lfu_pkg::ID_W-1:0] id;
      write_slot_limit(5'd2);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      id = 16'($urandom_range(0, 65535));
      repeat (40)
         send_request(id);
      send_request(id ^ 16'h0001);
      send_request(id ^ 16'h0002);
      send_request(id ^ 16'h0004);
   endtask

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.candidate_id <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.data         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_input_backpressure();
      test_random_settings();
      test_repeated_hits();
      wait_idle();
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
rtl/core/lfu_pkg.sv
rtl/core/lfu_req_if.sv
rtl/core/lfu_rsp_if.sv
rtl/core/lfu_csr_if.sv
rtl/core/lfu_table.sv
rtl/core/lfu_rank.sv
rtl/core/lfu_slot_replacement_unit.sv
tb/tb.sv
